FILE: sv/sre_pkg.sv
package sre_pkg;

	// Data memory geometry
	localparam int MEM_DEPTH = 128;
	localparam int MEM_AW = $clog2(MEM_DEPTH);

	// Decoupling queue between decode and execute
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	// Command codes of an input beat
	localparam logic CMD_EXEC = 1'b0;
	localparam logic CMD_PRELOAD = 1'b1;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_SLT = 4'd2,
		OP_OR = 4'd3,
		OP_NAND = 4'd4,
		OP_ADDI = 4'd5,
		OP_SLTI = 4'd6,
		OP_ORI = 4'd7,
		OP_LUI = 4'd8,
		OP_LW = 4'd9,
		OP_SW = 4'd10,
		OP_BEQ = 4'd11,
		OP_JALR = 4'd12,
		OP_J = 4'd13,
		OP_HALT = 4'd14
	} opcode_t;

	// Decoded beat handed from the front end to the execute side
	typedef struct packed {
		logic preload;
		opcode_t op;
		logic [3:0] rs;
		logic [3:0] rt;
		logic [3:0] rd;
		logic [15:0] imm;
		logic [6:0] load_addr;
		logic [31:0] load_data;
		logic [15:0] mark;
	} sre_uop_t;

	// Result held in the output stage
	typedef struct packed {
		logic [15:0] next_pc;
		logic halted;
		logic reg_write;
		logic [3:0] reg_index;
		logic [31:0] reg_value;
		logic is_load;
		logic load_ok;
		logic mem_fault;
		logic [15:0] used_regs;
	} sre_res_t;

endpackage

FILE: sv/sre_in_if.sv
interface sre_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic [31:0] instr_word;
	logic [6:0] load_addr;
	logic signed [31:0] load_data;

	modport source(output valid, output cmd, output instr_word, output load_addr,
		output load_data, input ready);
	modport sink(input valid, input cmd, input instr_word, input load_addr,
		input load_data, output ready);
endinterface

FILE: sv/sre_out_if.sv
interface sre_out_if;
	logic valid;
	logic ready;
	logic [15:0] next_pc;
	logic halted;
	logic reg_write;
	logic [3:0] reg_index;
	logic signed [31:0] reg_value;
	logic mem_fault;
	logic [15:0] used_regs;

	modport source(output valid, output next_pc, output halted, output reg_write,
		output reg_index, output reg_value, output mem_fault, output used_regs,
		input ready);
	modport sink(input valid, input next_pc, input halted, input reg_write,
		input reg_index, input reg_value, input mem_fault, input used_regs,
		output ready);
endinterface

FILE: sv/sre_front.sv
module sre_front (
	sre_in_if.sink in_ch,
	input logic q_full,
	output logic push,
	output sre_pkg::sre_uop_t push_uop
);
	import sre_pkg::*;

	logic [3:0] rs;
	logic [3:0] rt;
	logic [3:0] rd;
	opcode_t op;

	// Accept a beat whenever the queue has room
	assign in_ch.ready = !q_full;
	assign push = in_ch.valid && !q_full;

	assign op = opcode_t'(in_ch.instr_word[27:24]);
	assign rs = in_ch.instr_word[23:20];
	assign rt = in_ch.instr_word[19:16];
	assign rd = in_ch.instr_word[15:12];

	// Split the instruction word and work out which registers it touches
	always_comb begin
		push_uop.preload = (in_ch.cmd == CMD_PRELOAD);
		push_uop.op = op;
		push_uop.rs = rs;
		push_uop.rt = rt;
		push_uop.rd = rd;
		push_uop.imm = in_ch.instr_word[15:0];
		push_uop.load_addr = in_ch.load_addr;
		push_uop.load_data = in_ch.load_data;
		unique case (op)
			OP_ADD, OP_SUB, OP_SLT, OP_OR, OP_NAND: begin
				push_uop.mark = (16'd1 << rd) | (16'd1 << rs) | (16'd1 << rt);
			end
			OP_LUI: begin
				push_uop.mark = 16'd1 << rt;
			end
			OP_ADDI, OP_SLTI, OP_ORI, OP_LW, OP_SW, OP_BEQ, OP_JALR: begin
				push_uop.mark = (16'd1 << rs) | (16'd1 << rt);
			end
			default: begin
				push_uop.mark = 16'd0;
			end
		endcase
	end

endmodule

FILE: sv/sre_queue.sv
module sre_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input sre_pkg::sre_uop_t push_uop,
	output logic full,
	input logic pop,
	output logic head_valid,
	output sre_pkg::sre_uop_t head_uop
);
	import sre_pkg::*;

	sre_uop_t ent_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] cnt_q;

	assign full = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_uop = ent_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_uop;
		end
	end

endmodule

FILE: sv/sre_back.sv
module sre_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input sre_pkg::sre_uop_t head_uop,
	output logic pop,
	sre_out_if.source out_ch
);
	import sre_pkg::*;

	// Architectural state
	logic [15:0] pc_q;
	logic [31:0] rf_q [16];
	logic halt_q;
	logic [15:0] used_q;
	logic [31:0] mem_q [MEM_DEPTH];
	logic mem_vld_q [MEM_DEPTH];
	logic [31:0] mem_rdata_q;
	logic mem_rvld_q;

	// Output stage
	logic v_s2;
	sre_res_t res_s2;

	// Execute-stage signals
	logic fire;
	logic retire_load;
	logic [31:0] load_val;
	logic [31:0] a;
	logic [31:0] b;
	logic [31:0] simm;
	logic [32:0] sum33;
	logic addr_ok;
	logic [MEM_AW-1:0] addr_idx;
	logic [31:0] pre_addr32;
	logic pre_ok;
	logic [15:0] pc1;
	logic [16:0] link17;
	sre_res_t r;
	logic [15:0] pc_nxt;
	logic halt_nxt;
	logic [15:0] used_nxt;
	logic rf_we;
	logic mem_we;
	logic mem_re;
	logic [MEM_AW-1:0] mem_widx;
	logic [31:0] mem_wdata;

	assign fire = head_valid && (!v_s2 || out_ch.ready);
	assign pop = fire;
	assign retire_load = v_s2 && out_ch.ready && res_s2.is_load;

	// Load result waiting in the output stage, zero on fault or unwritten word
	assign load_val = (res_s2.load_ok && mem_rvld_q) ? mem_rdata_q : 32'd0;

	// Read operands, bypassing a load that has not yet been written back
	assign a = (v_s2 && res_s2.is_load && res_s2.reg_index == head_uop.rs) ?
		load_val : rf_q[head_uop.rs];
	assign b = (v_s2 && res_s2.is_load && res_s2.reg_index == head_uop.rt) ?
		load_val : rf_q[head_uop.rt];

	assign simm = {{16{head_uop.imm[15]}}, head_uop.imm};
	assign sum33 = {a[31], a} + {simm[31], simm};
	assign addr_ok = !sum33[32] && (sum33[31:0] < 32'(MEM_DEPTH));
	assign addr_idx = sum33[MEM_AW-1:0];
	assign pre_addr32 = 32'(head_uop.load_addr);
	assign pre_ok = (pre_addr32 < 32'(MEM_DEPTH));
	assign pc1 = pc_q + 16'd1;
	assign link17 = {1'b0, pc_q} + 17'd1;

	// Execute one beat
	always_comb begin
		r = '0;
		pc_nxt = pc_q;
		halt_nxt = halt_q;
		used_nxt = used_q;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_widx = pre_addr32[MEM_AW-1:0];
		mem_wdata = head_uop.load_data;
		if (head_uop.preload) begin
			mem_we = pre_ok;
			r.mem_fault = !pre_ok;
		end else if (!halt_q) begin
			pc_nxt = pc1;
			used_nxt = used_q | head_uop.mark;
			unique case (head_uop.op)
				OP_ADD: begin
					r.reg_write = 1'b1;
					r.reg_index = head_uop.rd;
					r.reg_value = a + b;
				end
				OP_SUB: begin
					r.reg_write = 1'b1;
					r.reg_index = head_uop.rd;
					r.reg_value = a - b;
				end
				OP_SLT: begin
					r.reg_write = 1'b1;
					r.reg_index = head_uop.rd;
					r.reg_value = {31'd0, $signed(a) < $signed(b)};
				end
				OP_OR: begin
					r.reg_write = 1'b1;
					r.reg_index = head_uop.rd;
					r.reg_value = a | b;
				end
				OP_NAND: begin
					r.reg_write = 1'b1;
					r.reg_index = head_uop.rd;
					r.reg_value = ~(a & b);
				end
				OP_ADDI: begin
					r.reg_write = 1'b1;
					r.reg_index = head_uop.rt;
					r.reg_value = a + simm;
				end
				OP_SLTI: begin
					r.reg_write = 1'b1;
					r.reg_index = head_uop.rt;
					r.reg_value = {31'd0, $signed(a) < $signed(simm)};
				end
				OP_ORI: begin
					r.reg_write = 1'b1;
					r.reg_index = head_uop.rt;
					r.reg_value = a | {16'd0, head_uop.imm};
				end
				OP_LUI: begin
					r.reg_write = 1'b1;
					r.reg_index = head_uop.rt;
					r.reg_value = {head_uop.imm, 16'd0};
				end
				OP_LW: begin
					r.reg_write = 1'b1;
					r.reg_index = head_uop.rt;
					r.is_load = 1'b1;
					r.load_ok = addr_ok;
					r.mem_fault = !addr_ok;
					mem_re = addr_ok;
				end
				OP_SW: begin
					r.mem_fault = !addr_ok;
					mem_we = addr_ok;
					mem_widx = addr_idx;
					mem_wdata = b;
				end
				OP_BEQ: begin
					if (a == b) begin
						pc_nxt = pc1 + simm[15:0];
					end
				end
				OP_JALR: begin
					r.reg_write = 1'b1;
					r.reg_index = head_uop.rt;
					r.reg_value = 32'(link17);
					pc_nxt = (head_uop.rs == head_uop.rt) ? pc1 : a[15:0];
				end
				OP_J: begin
					pc_nxt = head_uop.imm;
				end
				OP_HALT: begin
					halt_nxt = 1'b1;
				end
				default: begin
					pc_nxt = pc1;
				end
			endcase
		end
		r.next_pc = pc_nxt;
		r.halted = halt_nxt;
		r.used_regs = used_nxt;
	end

	assign rf_we = fire && r.reg_write && !r.is_load;

	// Update program counter, halt flag, used mask and output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			halt_q <= 1'b0;
			used_q <= '0;
			v_s2 <= 1'b0;
		end else begin
			if (fire) begin
				pc_q <= pc_nxt;
				halt_q <= halt_nxt;
				used_q <= used_nxt;
			end
			if (fire) begin
				v_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= r;
		end
	end

	// Write back registers; the younger write wins over a retiring load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < 16; i++) begin
				if (rf_we && r.reg_index == 4'(i)) begin
					rf_q[i] <= r.reg_value;
				end else if (retire_load && res_s2.reg_index == 4'(i)) begin
					rf_q[i] <= load_val;
				end
			end
		end
	end

	// Data memory with per-word written marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MEM_DEPTH; i++) begin
				mem_vld_q[i] <= 1'b0;
			end
		end else if (fire && mem_we) begin
			mem_vld_q[mem_widx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && mem_we) begin
			mem_q[mem_widx] <= mem_wdata;
		end
		if (fire && mem_re) begin
			mem_rdata_q <= mem_q[addr_idx];
			mem_rvld_q <= mem_vld_q[addr_idx];
		end
	end

	// Drive the result beat
	assign out_ch.valid = v_s2;
	assign out_ch.next_pc = res_s2.next_pc;
	assign out_ch.halted = res_s2.halted;
	assign out_ch.reg_write = res_s2.reg_write;
	assign out_ch.reg_index = res_s2.reg_index;
	assign out_ch.reg_value = res_s2.is_load ? load_val : res_s2.reg_value;
	assign out_ch.mem_fault = res_s2.mem_fault;
	assign out_ch.used_regs = res_s2.used_regs;

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared without reset");

	a_preload_keeps_pc: assert property (@(posedge clk) disable iff (!arst_n)
		fire && head_uop.preload |=> pc_q == $past(pc_q))
		else $error("preload changed the program counter");

	a_load_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && res_s2.is_load && !res_s2.load_ok |-> out_ch.reg_value == 32'd0
		&& out_ch.mem_fault)
		else $error("faulting load did not report zero with fault");

	a_used_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (used_q & $past(used_q)) == $past(used_q))
		else $error("used register mask lost a bit");

endmodule

FILE: sv/sixteen_reg_risc_instruction_executor_unit.sv
// Beats pass through the queue, then the registered output stage. Throughput: one
// beat per cycle unless out_ch.ready stalls the output stage; a load result is
// bypassed to the next instruction from the output stage, so no instruction waits
// on another. A two-entry queue between decode and execute absorbs output stalls.
// Reset clears pc, registers, halt flag, used mask and memory written marks at once.
module sixteen_reg_risc_instruction_executor_unit (
	input logic clk,
	input logic arst_n,
	sre_in_if.sink in_ch,
	sre_out_if.source out_ch
);
	import sre_pkg::*;

	logic push;
	logic q_full;
	logic pop;
	logic head_valid;
	sre_uop_t push_uop;
	sre_uop_t head_uop;

	sre_front u_front (
		.in_ch(in_ch),
		.q_full(q_full),
		.push(push),
		.push_uop(push_uop)
	);

	sre_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_uop(push_uop),
		.full(q_full),
		.pop(pop),
		.head_valid(head_valid),
		.head_uop(head_uop)
	);

	sre_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_uop(head_uop),
		.pop(pop),
		.out_ch(out_ch)
	);

endmodule
